// ===== rtl/mps_pkg.sv =====
// ----------------------------------------------------------------------------
// Magnet pulse sequencer package
// Shared types, register indexes, drive bit positions and the step table.
// ----------------------------------------------------------------------------
package mps_pkg;

	localparam int unsigned NUM_MAGNETS = 70;
	localparam int unsigned NUM_STEPS   = 10;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned CNT_W      = 17;
	localparam int unsigned PHASE_W    = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LEAD      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_DT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_H_DT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COM_H_DT  = 3'd5;

	// Command codes.
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_STARTED  = 2'd1;
	localparam logic [1:0] ST_REJECTED = 2'd2;
	localparam logic [1:0] ST_FINISHED = 2'd3;

	// Drive bit masks.
	localparam logic [3:0] DRV_NONE = 4'b0000;
	localparam logic [3:0] DRV_GH   = 4'b0001;
	localparam logic [3:0] DRV_GL   = 4'b0010;
	localparam logic [3:0] DRV_CH   = 4'b0100;
	localparam logic [3:0] DRV_CL   = 4'b1000;

	// Wait selections, numbered like the configuration registers.
	localparam logic [2:0] W_LEAD   = 3'd0;
	localparam logic [2:0] W_PULSE  = 3'd1;
	localparam logic [2:0] W_SETTLE = 3'd2;
	localparam logic [2:0] W_LOWDT  = 3'd3;
	localparam logic [2:0] W_GHDT   = 3'd4;
	localparam logic [2:0] W_CHDT   = 3'd5;

	typedef struct packed {
		logic [3:0] entry_off;
		logic [2:0] wait_sel;
		logic [3:0] end_off;
		logic [3:0] end_on;
	} step_t;

	typedef struct packed {
		logic [6:0] mux_address;
		logic       gate_high;
		logic       gate_low;
		logic       common_high;
		logic       common_low;
		logic       busy_res;
		logic [1:0] status;
	} result_t;

	function automatic step_t mk_step(logic [3:0] eo, logic [2:0] ws, logic [3:0] xo,
			logic [3:0] xn);
		step_t s;
		s.entry_off = eo;
		s.wait_sel  = ws;
		s.end_off   = xo;
		s.end_on    = xn;
		return s;
	endfunction

	// Step list per polarity; step is 0 based.
	function automatic step_t seq_step(logic pol, logic [PHASE_W-1:0] step);
		step_t s;
		s = mk_step(DRV_NONE, W_LEAD, DRV_NONE, DRV_NONE);
		if (pol) begin
			unique case (step)
				4'd0: s = mk_step(DRV_GH | DRV_GL, W_LOWDT, DRV_NONE, DRV_GL);
				4'd1: s = mk_step(DRV_CH, W_LOWDT, DRV_NONE, DRV_CL);
				4'd2: s = mk_step(DRV_NONE, W_LEAD, DRV_NONE, DRV_NONE);
				4'd3: s = mk_step(DRV_CL, W_CHDT, DRV_NONE, DRV_CH);
				4'd4: s = mk_step(DRV_NONE, W_PULSE, DRV_NONE, DRV_NONE);
				4'd5: s = mk_step(DRV_CH, W_LOWDT, DRV_NONE, DRV_CL);
				4'd6: s = mk_step(DRV_GH | DRV_GL, W_LOWDT, DRV_NONE, DRV_GL);
				4'd7: s = mk_step(DRV_NONE, W_SETTLE, DRV_NONE, DRV_NONE);
				4'd8: s = mk_step(DRV_GH | DRV_GL, W_GHDT, DRV_GH, DRV_NONE);
				4'd9: s = mk_step(DRV_CL, W_GHDT, DRV_CH, DRV_NONE);
				default: s = mk_step(DRV_NONE, W_LEAD, DRV_NONE, DRV_NONE);
			endcase
		end else begin
			unique case (step)
				4'd0: s = mk_step(DRV_GH | DRV_GL, W_LOWDT, DRV_NONE, DRV_GL);
				4'd1: s = mk_step(DRV_CH, W_LOWDT, DRV_NONE, DRV_CL);
				4'd2: s = mk_step(DRV_NONE, W_LEAD, DRV_NONE, DRV_NONE);
				4'd3: s = mk_step(DRV_GH | DRV_GL, W_GHDT, DRV_NONE, DRV_GH);
				4'd4: s = mk_step(DRV_NONE, W_PULSE, DRV_NONE, DRV_NONE);
				4'd5: s = mk_step(DRV_GH | DRV_GL, W_LOWDT, DRV_NONE, DRV_GL);
				4'd6: s = mk_step(DRV_CH, W_LOWDT, DRV_NONE, DRV_CL);
				4'd7: s = mk_step(DRV_NONE, W_SETTLE, DRV_NONE, DRV_NONE);
				4'd8: s = mk_step(DRV_GH | DRV_GL, W_GHDT, DRV_GH, DRV_NONE);
				4'd9: s = mk_step(DRV_CL, W_GHDT, DRV_CH, DRV_NONE);
				default: s = mk_step(DRV_NONE, W_LEAD, DRV_NONE, DRV_NONE);
			endcase
		end
		return s;
	endfunction

endpackage

// ===== rtl/mps_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Magnet pulse sequencer command channel
// Valid/ready channel carrying tick and start requests.
// ----------------------------------------------------------------------------
interface mps_cmd_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic       polarity;
	logic [6:0] magnet_index;

	modport source (output valid, output command, output polarity, output magnet_index,
		input ready);
	modport sink (input valid, input command, input polarity, input magnet_index,
		output ready);
endinterface

// ===== rtl/mps_res_if.sv =====
// ----------------------------------------------------------------------------
// Magnet pulse sequencer result channel
// Valid/ready channel carrying drive levels and status after each request.
// ----------------------------------------------------------------------------
interface mps_res_if;
	logic       valid;
	logic       ready;
	logic [6:0] mux_address;
	logic       gate_high;
	logic       gate_low;
	logic       common_high;
	logic       common_low;
	logic       busy_res;
	logic [1:0] status;

	modport source (output valid, output mux_address, output gate_high, output gate_low,
		output common_high, output common_low, output busy_res, output status,
		input ready);
	modport sink (input valid, input mux_address, input gate_high, input gate_low,
		input common_high, input common_low, input busy_res, input status,
		output ready);
endinterface

// ===== rtl/magnet_pulse_sequencer_core.sv =====
// Accepts one request per clock whenever the result register is empty or being
// taken in the same cycle, and returns one result per request, valid in the cycle
// after acceptance. The next state and the result are computed combinationally
// from the request and the sequencer registers.
// ----------------------------------------------------------------------------
// Magnet pulse sequencer core
// Steps the H-bridge gates through lead, pulse, settle and release with dead
// times between switch-overs, counting one-microsecond tick requests.
// ----------------------------------------------------------------------------
module magnet_pulse_sequencer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	mps_cmd_if.sink                           cmd,
	mps_res_if.source                         res
);

	logic [15:0] lead_time_q;
	logic [15:0] pulse_time_q;
	logic [16:0] settle_time_q;
	logic [7:0]  low_dt_q;
	logic [7:0]  gate_h_dt_q;
	logic [7:0]  com_h_dt_q;

	logic [mps_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [mps_pkg::CNT_W-1:0]   countdown_q, countdown_d, cnt_dec;
	logic                        pol_q, pol_d;
	logic [6:0]                  addr_q, addr_d;
	logic [3:0]                  drive_q, drive_d, drive_end;
	logic [1:0]                  status_d;

	logic                 out_valid_q;
	mps_pkg::result_t     res_q;
	logic                 accept;
	logic                 busy;
	logic                 idx_bad;
	mps_pkg::step_t       cur_step, next_step, first_step;
	logic [mps_pkg::PHASE_W-1:0] step_idx;

	assign cmd.ready = !out_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_time_q   <= 16'd1000;
			pulse_time_q  <= 16'd100;
			settle_time_q <= 17'd100000;
			low_dt_q      <= 8'd10;
			gate_h_dt_q   <= 8'd5;
			com_h_dt_q    <= 8'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mps_pkg::REG_LEAD:      lead_time_q   <= cfg_wdata[15:0];
				mps_pkg::REG_PULSE:     pulse_time_q  <= cfg_wdata[15:0];
				mps_pkg::REG_SETTLE:    settle_time_q <= cfg_wdata[16:0];
				mps_pkg::REG_LOW_DT:    low_dt_q      <= cfg_wdata[7:0];
				mps_pkg::REG_GATE_H_DT: gate_h_dt_q   <= cfg_wdata[7:0];
				mps_pkg::REG_COM_H_DT:  com_h_dt_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	function automatic logic [mps_pkg::CNT_W-1:0] wait_value(logic [2:0] sel,
			logic [15:0] lead, logic [15:0] pulse, logic [16:0] settle,
			logic [7:0] lowdt, logic [7:0] ghdt, logic [7:0] chdt);
		logic [mps_pkg::CNT_W-1:0] v;
		unique case (sel)
			mps_pkg::W_LEAD:   v = {1'b0, lead};
			mps_pkg::W_PULSE:  v = {1'b0, pulse};
			mps_pkg::W_SETTLE: v = settle;
			mps_pkg::W_LOWDT:  v = {9'd0, lowdt};
			mps_pkg::W_GHDT:   v = {9'd0, ghdt};
			default:           v = {9'd0, chdt};
		endcase
		return v;
	endfunction

	assign busy     = (phase_q != '0);
	assign idx_bad  = ({1'b0, cmd.magnet_index} >= 8'(mps_pkg::NUM_MAGNETS));
	assign step_idx = phase_q - 4'd1;
	assign cur_step   = mps_pkg::seq_step(pol_q, step_idx);
	assign next_step  = mps_pkg::seq_step(pol_q, phase_q);
	assign first_step = mps_pkg::seq_step(cmd.polarity, 4'd0);
	assign cnt_dec    = (countdown_q != '0) ? countdown_q - 17'd1 : countdown_q;
	assign drive_end  = (drive_q & ~cur_step.end_off) | cur_step.end_on;

	always_comb begin
		phase_d     = phase_q;
		countdown_d = countdown_q;
		pol_d       = pol_q;
		addr_d      = addr_q;
		drive_d     = drive_q;
		status_d    = mps_pkg::ST_NONE;
		if (cmd.command == mps_pkg::CMD_START) begin
			if (busy || idx_bad) begin
				status_d = mps_pkg::ST_REJECTED;
			end else begin
				pol_d       = cmd.polarity;
				addr_d      = cmd.magnet_index;
				phase_d     = 4'd1;
				drive_d     = drive_q & ~first_step.entry_off;
				countdown_d = wait_value(first_step.wait_sel, lead_time_q, pulse_time_q,
					settle_time_q, low_dt_q, gate_h_dt_q, com_h_dt_q);
				status_d    = mps_pkg::ST_STARTED;
			end
		end else if (busy) begin
			countdown_d = cnt_dec;
			if (cnt_dec == '0) begin
				if (phase_q >= 4'(mps_pkg::NUM_STEPS)) begin
					drive_d  = drive_end;
					phase_d  = '0;
					status_d = mps_pkg::ST_FINISHED;
				end else begin
					// Final gate change of this step, then the next step's turn-off.
					drive_d     = drive_end & ~next_step.entry_off;
					phase_d     = phase_q + 4'd1;
					countdown_d = wait_value(next_step.wait_sel, lead_time_q, pulse_time_q,
						settle_time_q, low_dt_q, gate_h_dt_q, com_h_dt_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			countdown_q <= '0;
			pol_q       <= 1'b0;
			addr_q      <= '0;
			drive_q     <= mps_pkg::DRV_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				countdown_q <= countdown_d;
				pol_q       <= pol_d;
				addr_q      <= addr_d;
				drive_q     <= drive_d;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.mux_address <= addr_d;
			res_q.gate_high   <= drive_d[0];
			res_q.gate_low    <= drive_d[1];
			res_q.common_high <= drive_d[2];
			res_q.common_low  <= drive_d[3];
			res_q.busy_res    <= (phase_d != '0);
			res_q.status      <= status_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.mux_address = res_q.mux_address;
	assign res.gate_high   = res_q.gate_high;
	assign res.gate_low    = res_q.gate_low;
	assign res.common_high = res_q.common_high;
	assign res.common_low  = res_q.common_low;
	assign res.busy_res    = res_q.busy_res;
	assign res.status      = res_q.status;

`ifndef SYNTHESIS
	a_no_shoot_gate: assert property (@(posedge clk) disable iff (!arst_n)
		!((drive_q & mps_pkg::DRV_GH) != '0 && (drive_q & mps_pkg::DRV_GL) != '0))
		else $error("magnet gate high and low on together");
	a_no_shoot_common: assert property (@(posedge clk) disable iff (!arst_n)
		!((drive_q & mps_pkg::DRV_CH) != '0 && (drive_q & mps_pkg::DRV_CL) != '0))
		else $error("common high and low on together");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= 4'(mps_pkg::NUM_STEPS))
		else $error("phase beyond the last step");
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(countdown_q != '0) |-> (phase_q != '0))
		else $error("countdown running while idle");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.ready) |=> ($stable(res_q) && out_valid_q))
		else $error("pending result changed before it was taken");
`endif

endmodule
